// File: design/ple_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared widths, request codes and status codes of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int REQ_W     = 3;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 7;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 6;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_BACK  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_INS_AT    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DEL_AT    = 3'd5;
  localparam logic [REQ_W-1:0] REQ_DISPLAY   = 3'd6;
  localparam logic [REQ_W-1:0] REQ_COUNT     = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

endpackage
`default_nettype wire

// File: design/ple_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_store
// Element memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ple_store
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IW       = $clog2(CAPACITY)
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [IW-1:0]      waddr,
  input  wire logic [VALUE_W-1:0] wdata,
  input  wire logic               re,
  input  wire logic [IW-1:0]      raddr,
  output logic      [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/ple_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ctrl
// Request sequencer with the shared circular slot adder and the result register.
// ----------------------------------------------------------------------------
module ple_ctrl
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [REQ_W-1:0]    in_req,
  input  wire logic [VALUE_W-1:0]  in_value,
  input  wire logic [POS_W-1:0]    in_pos,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [VALUE_W-1:0]       out_elem,
  output logic [COUNT_W-1:0]       out_count,
  output logic                     out_last,
  output logic                     mem_we,
  output logic [IW-1:0]            mem_waddr,
  output logic [VALUE_W-1:0]       mem_wdata,
  output logic                     mem_re,
  output logic [IW-1:0]            mem_raddr,
  input  wire logic [VALUE_W-1:0]  mem_rdata
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_RD   = 4'd1;
  localparam logic [3:0] S_INS_WR   = 4'd2;
  localparam logic [3:0] S_WR_NEW   = 4'd3;
  localparam logic [3:0] S_DEL_RD   = 4'd4;
  localparam logic [3:0] S_DEL_WR   = 4'd5;
  localparam logic [3:0] S_DISP_RD  = 4'd6;
  localparam logic [3:0] S_DISP_OUT = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  localparam logic [CW:0] CAP_X = (CW + 1)'(CAPACITY);

  logic [3:0]          state, state_next;
  logic [IW-1:0]       head, head_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       idx, idx_next;
  logic [CW-1:0]       stop, stop_next;
  logic [VALUE_W-1:0]  val, val_next;
  logic [STATUS_W-1:0] st, st_next;

  logic                load_out;
  logic [STATUS_W-1:0] ld_status;
  logic [VALUE_W-1:0]  ld_elem;
  logic                ld_last;

  logic [CW:0]   off;
  logic [CW:0]   sum;
  logic [IW-1:0] slot_addr;

  logic          slot_free;
  logic          full, empty;
  logic [7:0]    pos_x, cnt_x;
  logic          ins_bad, del_bad;
  logic [CW-1:0] pos_m1;
  logic [CW-1:0] ins_p, del_p;
  logic [CW:0]   idx_p1, idx_p2;

  // Shared slot adder: (head + offset) wrapped to the buffer size.
  always_comb begin
    sum = (CW + 1)'(head) + off;
    if (sum >= CAP_X) begin
      sum = sum - CAP_X;
    end
    slot_addr = IW'(sum);
  end

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign pos_x     = 8'(in_pos);
  assign cnt_x     = 8'(count);
  assign ins_bad   = (in_pos == '0) || (pos_x > cnt_x + 8'd1);
  assign del_bad   = (in_pos == '0) || (pos_x > cnt_x);
  assign pos_m1    = CW'(pos_x - 8'd1);
  assign ins_p     = (in_req == REQ_INS_FRONT) ? '0 :
                     (in_req == REQ_INS_BACK)  ? count : pos_m1;
  assign del_p     = (in_req == REQ_DEL_FRONT) ? '0 :
                     (in_req == REQ_DEL_BACK)  ? CW'(count - 1'b1) : pos_m1;
  assign idx_p1    = (CW + 1)'(idx) + 1'b1;
  assign idx_p2    = idx_p1 + 1'b1;

  assign mem_waddr = slot_addr;
  assign mem_raddr = slot_addr;

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    idx_next   = idx;
    stop_next  = stop;
    val_next   = val;
    st_next    = st;
    off        = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wdata  = mem_rdata;
    load_out   = 1'b0;
    ld_status  = st;
    ld_elem    = '0;
    ld_last    = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          val_next   = in_value;
          st_next    = ST_OK;
          state_next = S_FINISH;
          unique case (in_req)
            REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
              if (full) begin
                st_next = ST_FULL;
              end else if (in_req == REQ_INS_AT && ins_bad) begin
                st_next = ST_BADPOS;
              end else if (ins_p == '0) begin
                off        = CAP_X - 1'b1;
                head_next  = slot_addr;
                idx_next   = '0;
                state_next = S_WR_NEW;
              end else if (count > ins_p) begin
                idx_next   = count;
                stop_next  = ins_p;
                state_next = S_INS_RD;
              end else begin
                idx_next   = ins_p;
                state_next = S_WR_NEW;
              end
            end
            REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
              if (empty) begin
                st_next = ST_EMPTY;
              end else if (in_req == REQ_DEL_AT && del_bad) begin
                st_next = ST_BADPOS;
              end else if (del_p == '0) begin
                off        = (CW + 1)'(1);
                head_next  = slot_addr;
                count_next = count - 1'b1;
              end else if ((CW + 1)'(del_p) + 1'b1 < (CW + 1)'(count)) begin
                idx_next   = del_p;
                state_next = S_DEL_RD;
              end else begin
                count_next = count - 1'b1;
              end
            end
            REQ_DISPLAY: begin
              if (empty) begin
                st_next = ST_EMPTY;
              end else begin
                idx_next   = '0;
                state_next = S_DISP_RD;
              end
            end
            REQ_COUNT: begin
              st_next = ST_OK;
            end
            default: begin
              st_next = ST_OK;
            end
          endcase
        end
      end
      S_INS_RD: begin
        off        = (CW + 1)'(idx) - 1'b1;
        mem_re     = 1'b1;
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        off      = (CW + 1)'(idx);
        mem_we   = 1'b1;
        idx_next = idx - 1'b1;
        if (idx - 1'b1 == stop) begin
          state_next = S_WR_NEW;
        end else begin
          state_next = S_INS_RD;
        end
      end
      S_WR_NEW: begin
        off        = (CW + 1)'(idx);
        mem_we     = 1'b1;
        mem_wdata  = val;
        count_next = count + 1'b1;
        state_next = S_FINISH;
      end
      S_DEL_RD: begin
        off        = idx_p1;
        mem_re     = 1'b1;
        state_next = S_DEL_WR;
      end
      S_DEL_WR: begin
        off      = (CW + 1)'(idx);
        mem_we   = 1'b1;
        idx_next = CW'(idx_p1);
        if (idx_p2 >= (CW + 1)'(count)) begin
          count_next = count - 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_DEL_RD;
        end
      end
      S_DISP_RD: begin
        off        = (CW + 1)'(idx);
        mem_re     = 1'b1;
        state_next = S_DISP_OUT;
      end
      S_DISP_OUT: begin
        ld_status = ST_OK;
        ld_elem   = mem_rdata;
        ld_last   = (idx_p1 == (CW + 1)'(count));
        if (slot_free) begin
          load_out = 1'b1;
          idx_next = CW'(idx_p1);
          if (ld_last) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_DISP_RD;
          end
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    stop <= stop_next;
    val  <= val_next;
    st   <= st_next;
    if (load_out) begin
      out_status <= ld_status;
      out_elem   <= ld_elem;
      out_count  <= COUNT_W'(count_next);
      out_last   <= ld_last;
    end
  end

endmodule
`default_nettype wire

// File: design/positional_list_engine.sv
`default_nettype none
// Front/back deletes, count and rejected requests go straight to the result register, and
// front/back inserts first write the new element. Positional inserts and deletes first move
// each shifted entry by a read and a write. Display uses the single registered memory read port.
// One request is in work at a time; s_tready is high only between requests.
// Synchronous reset empties the list; the element memory itself is not cleared.
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values held in a circular buffer with a head index.
// ----------------------------------------------------------------------------
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [S_TDATA_W-1:0]   s_tdata,  // value[31:0], position[38:32], zero pad
  input  wire logic [REQ_W-1:0]       s_tuser,  // req_type[2:0]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [M_TDATA_W-1:0]        m_tdata,  // element[31:0], element_count[37:32], pad
  output logic [STATUS_W-1:0]         m_tuser,  // status[1:0]
  output logic                        m_tlast
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;
  logic [VALUE_W-1:0] out_elem;
  logic [COUNT_W-1:0] out_count;

  ple_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_req     (s_tuser),
    .in_value   (s_tdata[VALUE_W-1:0]),
    .in_pos     (s_tdata[VALUE_W+POS_W-1:VALUE_W]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_elem   (out_elem),
    .out_count  (out_count),
    .out_last   (m_tlast),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  ple_store #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign m_tdata = {{(M_TDATA_W - VALUE_W - COUNT_W){1'b0}}, out_count, out_elem};

endmodule
`default_nettype wire
